// File: design/bfm_pkg.sv
`timescale 1ns / 1ps

package bfm_pkg;

  // Default sizes of the matcher.
  localparam int unsigned MaxErrorsLimitDef = 7;
  localparam int unsigned PatternMaxDef     = 31;
  localparam int unsigned PositionBitsDef   = 16;

  // Pattern storage in the register file is fixed at 32 bytes.
  localparam int unsigned PatBytes   = 32;
  localparam int unsigned PatWordW   = 64;
  localparam int unsigned LenW       = 5;
  localparam int unsigned ErrW       = 3;
  localparam int unsigned PosOutW    = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ERRORS     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_LO     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_MID    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_HIGH   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_TOP    = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_of_text;
    logic       end_of_text;
  } bfm_in_t;

  typedef struct packed {
    logic               found;
    logic [PosOutW-1:0] position;
  } bfm_out_t;

  // Control handed to every cell of the row chain.
  typedef struct packed {
    logic restart;  // request carries start of text: cells begin from the reset row
    logic advance;  // cells take their new row value
  } bfm_step_t;

endpackage

// File: design/bfm_match_mask.sv
`timescale 1ns / 1ps

module bfm_match_mask import bfm_pkg::*; #(
  parameter int unsigned RowW = PatternMaxDef + 1
) (
  input  logic [7:0]            text_byte_i,
  input  logic [PatBytes*8-1:0] pattern_i,
  input  logic [LenW-1:0]       length_i,
  input  logic                  usable_i,
  output logic [RowW-1:0]       mask_o
);

  localparam int unsigned MaskW = (RowW < PatBytes) ? RowW : PatBytes;

  // One byte comparator per pattern position, all in parallel.
  for (genvar i = 0; i < RowW; i++) begin : g_bit
    if (i < MaskW) begin : g_cmp
      assign mask_o[i] = usable_i && (32'(i) < 32'(length_i)) &&
                         (pattern_i[i*8 +: 8] == text_byte_i);
    end else begin : g_zero
      assign mask_o[i] = 1'b0;
    end
  end

endmodule

// File: design/bfm_cell.sv
`timescale 1ns / 1ps

module bfm_cell import bfm_pkg::*; #(
  parameter int unsigned RowW = PatternMaxDef + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfm_step_t       step_i,
  input  logic [RowW-1:0] mask_i,
  input  logic [RowW-1:0] prev_old_i,
  input  logic [RowW-1:0] prev_new_i,
  output logic [RowW-1:0] row_old_o,
  output logic [RowW-1:0] row_new_o
);

  logic [RowW-1:0] row_q;
  logic [RowW-1:0] row_cur;
  logic [RowW-1:0] hit;
  logic [RowW-1:0] ins_v;
  logic [RowW-1:0] del_v;
  logic [RowW-1:0] sub_v;

  // A new text starts every row with only the empty prefix matched.
  assign row_cur = step_i.restart ? RowW'(1) : row_q;
  assign hit     = row_cur & mask_i;
  assign ins_v   = prev_old_i | (hit << 1);
  assign del_v   = (prev_new_i | hit) << 1;
  assign sub_v   = (prev_old_i | hit) << 1;

  assign row_old_o = row_cur;
  assign row_new_o = ins_v | del_v | sub_v | RowW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= RowW'(1);
    end else if (step_i.advance) begin
      row_q <= row_new_o;
    end
  end

endmodule

// File: design/bitap_fuzzy_match_core.sv
`timescale 1ns / 1ps

// Approximate string matcher (bitap with insertions, deletions, substitutions).
// Input channel: one text byte per request with start and end markers; a start
// marker clears the error rows, the byte counter and the done flag first.
// Output channel: at most one result per text, either the byte index where the
// first match within the error limit ends, or not found at the end of text.
// After a result the rest of the text is consumed without results.
// Configuration is a plain write port (pattern length, error limit, four
// pattern words) and must only be written while the block is idle.
// Throughput is one byte per cycle while the receiver keeps up: the row chain
// updates all error levels together, one cell per level. The result is
// registered and appears in the cycle after its request is accepted. The input
// keeps flowing while a result waits, as long as the output register is free or
// being drained; a stalled receiver holding a result stalls the input.
// Reset clears the configuration to zero, which never matches, and puts each
// row at the reset value. No clearing pass is needed after reset.
module bitap_fuzzy_match_core import bfm_pkg::*; #(
  parameter int unsigned MaxErrorsLimit = MaxErrorsLimitDef,
  parameter int unsigned PatternMax     = PatternMaxDef,
  parameter int unsigned PositionBits   = PositionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfm_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bfm_out_t            out_data_o
);

  localparam int unsigned RowW = PatternMax + 1;
  localparam int unsigned Rows = MaxErrorsLimit + 1;

  // Configuration registers
  logic [LenW-1:0]       len_q;
  logic [ErrW-1:0]       max_err_q;
  logic [PatBytes*8-1:0] pattern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      max_err_q <= '0;
      pattern_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_LENGTH: len_q <= cfg_wdata_i[LenW-1:0];
        CFG_MAX_ERRORS:     max_err_q <= cfg_wdata_i[ErrW-1:0];
        CFG_PATTERN_LO:     pattern_q[0*PatWordW +: PatWordW] <= cfg_wdata_i;
        CFG_PATTERN_MID:    pattern_q[1*PatWordW +: PatWordW] <= cfg_wdata_i;
        CFG_PATTERN_HIGH:   pattern_q[2*PatWordW +: PatWordW] <= cfg_wdata_i;
        CFG_PATTERN_TOP:    pattern_q[3*PatWordW +: PatWordW] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Text state
  logic                    done_q;
  logic [PositionBits-1:0] pos_q;
  logic                    out_valid_q;
  bfm_out_t                out_q;

  logic                    in_acc;
  logic                    done_cur;
  logic [PositionBits-1:0] pos_cur;
  logic                    active;
  logic                    usable;
  logic                    hit;
  logic                    res_fire;
  logic [ErrW-1:0]         k_amt;
  logic [Rows-1:0]         k_onehot;
  logic [RowW-1:0]         len_onehot;
  logic [RowW-1:0]         mask;
  logic [Rows-1:0]         match_bits;
  logic [RowW-1:0]         row_old [Rows];
  logic [RowW-1:0]         row_new [Rows];
  bfm_step_t               step;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign done_cur = in_data_i.start_of_text ? 1'b0 : done_q;
  assign pos_cur  = in_data_i.start_of_text ? '0 : pos_q;
  assign active   = in_acc && !done_cur;

  assign step.restart = in_acc && in_data_i.start_of_text;
  assign step.advance = active;

  assign usable = (len_q != '0) && (32'(len_q) <= 32'(PatternMax));

  bfm_match_mask #(
    .RowW (RowW)
  ) u_mask (
    .text_byte_i (in_data_i.text_byte),
    .pattern_i   (pattern_q),
    .length_i    (len_q),
    .usable_i    (usable),
    .mask_o      (mask)
  );

  for (genvar d = 0; d < Rows; d++) begin : g_cell
    logic [RowW-1:0] prev_old;
    logic [RowW-1:0] prev_new;

    if (d == 0) begin : g_first
      assign prev_old = '0;
      assign prev_new = '0;
    end else begin : g_next
      assign prev_old = row_old[d-1];
      assign prev_new = row_new[d-1];
    end

    bfm_cell #(
      .RowW (RowW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .mask_i     (mask),
      .prev_old_i (prev_old),
      .prev_new_i (prev_new),
      .row_old_o  (row_old[d]),
      .row_new_o  (row_new[d])
    );

    assign match_bits[d] = |(row_new[d] & len_onehot);
  end

  // Error limits beyond the number of rows fall back to the last row.
  assign k_amt      = (32'(max_err_q) > 32'(MaxErrorsLimit)) ? ErrW'(MaxErrorsLimit)
                                                             : max_err_q;
  assign k_onehot   = Rows'(1) << k_amt;
  assign len_onehot = RowW'(1) << len_q;
  assign hit        = usable && |(match_bits & k_onehot);
  assign res_fire   = active && (hit || in_data_i.end_of_text);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        done_q <= done_cur || res_fire;
        if (!done_cur) begin
          pos_q <= (pos_cur != '1) ? pos_cur + PositionBits'(1) : pos_cur;
        end else begin
          pos_q <= pos_cur;
        end
      end
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_q.found    <= hit;
      out_q.position <= hit ? PosOutW'(pos_cur) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_result_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |=> done_q)
    else $error("result issued without marking the text as done");

  a_done_holds_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && done_q && !in_data_i.start_of_text |=> $stable(pos_q) && done_q)
    else $error("byte counter moved after the text was done");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.position == '0)
    else $error("not found result carries a nonzero position");

  a_row_base_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_old[0][0] && row_new[Rows-1][0])
    else $error("empty prefix bit lost in the row chain");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bfm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned PHASE_BYTES   = 40;
  localparam int unsigned FILL_BYTES    = 260;
  localparam int unsigned ROWS          = MaxErrorsLimitDef + 1;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_7 = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = '0;
  logic [CfgDataW-1:0] cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready_o;
  bfm_in_t             in_data     = '0;
  logic                out_valid_o;
  logic                out_ready   = 1'b0;
  bfm_out_t            out_data_o;

  // Mirror of the matcher: configuration and per-text state.
  logic [LenW-1:0]     pat_len     = '0;
  logic [ErrW-1:0]     err_lim     = '0;
  logic [63:0]         pat_words [4] = '{default: '0};
  logic [31:0]         row_vec [ROWS] = '{default: 32'd1};
  logic [15:0]         text_pos    = '0;
  logic                text_closed = 1'b0;

  bfm_out_t            pending_results [$];
  int unsigned         live_items     = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;

  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;
  bit                  stall_req  = 1'b0;
  int unsigned         stall_left = 0;

  bitap_fuzzy_match_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_text();
    int d;
    for (d = 0; d < ROWS; d++) row_vec[d] = 32'd1;
    text_pos    = '0;
    text_closed = 1'b0;
  endtask

  // Advance the row chain by one text byte and queue the result it causes.
  task automatic advance_matcher(input bfm_in_t req);
    logic [31:0] hit_mask, hit, prev_old, prev_new, ins, del, sub;
    logic [15:0] pos_now;
    bfm_out_t    res;
    int          i, d;
    if (req.start_of_text) clear_text();
    if (text_closed) return;
    live_items++;
    hit_mask = '0;
    for (i = 0; i < pat_len; i++) begin
      if (pat_words[i / 8][(i % 8) * 8 +: 8] == req.text_byte) hit_mask[i] = 1'b1;
    end
    prev_old = '0;
    prev_new = '0;
    for (d = 0; d < ROWS; d++) begin
      hit        = row_vec[d] & hit_mask;
      ins        = prev_old | (hit << 1);
      del        = (prev_new | hit) << 1;
      sub        = (prev_old | hit) << 1;
      prev_old   = row_vec[d];
      row_vec[d] = ins | del | sub | 32'd1;
      prev_new   = row_vec[d];
    end
    pos_now = text_pos;
    if (text_pos != 16'hFFFF) text_pos++;
    if (pat_len != 0 && row_vec[err_lim][pat_len]) begin
      text_closed   = 1'b1;
      res.found     = 1'b1;
      res.position  = pos_now;
      pending_results.push_back(res);
    end else if (req.end_of_text) begin
      text_closed   = 1'b1;
      res.found     = 1'b0;
      res.position  = '0;
      pending_results.push_back(res);
    end
  endtask

  // Results are checked before the request of the same edge is predicted;
  // a result can never belong to a request accepted at that same edge.
  always @(posedge clk_i) begin
    bfm_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_data_o), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.found !== want.found)
            report_mismatch("found", 32'(out_data_o.found), 32'(want.found));
          if (out_data_o.position !== want.position)
            report_mismatch("position", 32'(out_data_o.position), 32'(want.position));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PATTERN_LENGTH: pat_len = cfg_wdata[LenW-1:0];
          CFG_MAX_ERRORS:     err_lim = cfg_wdata[ErrW-1:0];
          CFG_PATTERN_LO:     pat_words[0] = cfg_wdata;
          CFG_PATTERN_MID:    pat_words[1] = cfg_wdata;
          CFG_PATTERN_HIGH:   pat_words[2] = cfg_wdata;
          CFG_PATTERN_TOP:    pat_words[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) advance_matcher(in_data);
    end
  end

  // Receiver: random idling, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (stall_req) begin
      stall_left = HOLD_CYCLES;
      stall_req  = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(99) < 38);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sot, input logic eot);
    bfm_in_t req;
    req.text_byte     = b;
    req.start_of_text = sot;
    req.end_of_text   = eot;
    while (tx_idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == 0, i == s.len() - 1);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let every expected result arrive, then give a trailing byte with no
  // result time to leave the block.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // Right after reset the pattern is empty, so the text ends not found.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    wait_quiet();
    write_reg(CFG_PATTERN_LO, 64'h0000_0000_0063_6261);
    write_reg(CFG_PATTERN_LENGTH, 64'd3);
    write_reg(CFG_MAX_ERRORS, 64'd0);
    write_reg(CFG_SPARE_6, '1);
    write_reg(CFG_SPARE_7, '1);
    send_str("xabcz");
    // No start marker: the text already reported, so this byte is dropped.
    send_byte("q", 1'b0, 1'b1);
    send_str("abc");
    send_str("ab");
    wait_quiet();
    write_reg(CFG_MAX_ERRORS, 64'd1);
    send_str("axc");
    send_str("ac");
    send_str("zbxc");
    wait_quiet();
    write_reg(CFG_PATTERN_LO, '1);
    write_reg(CFG_PATTERN_MID, '1);
    write_reg(CFG_PATTERN_HIGH, '1);
    write_reg(CFG_PATTERN_TOP, '1);
    write_reg(CFG_PATTERN_LENGTH, 64'd31);
    write_reg(CFG_MAX_ERRORS, 64'd7);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    wait_quiet();
  endtask

  // A long text pushes the byte counter past the width of one byte before
  // the match, with no idling on either side.
  task automatic test_long_text();
    int unsigned n;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_reg(CFG_PATTERN_LO, 64'h0000_0000_0000_6261);
    write_reg(CFG_PATTERN_MID, '0);
    write_reg(CFG_PATTERN_HIGH, '0);
    write_reg(CFG_PATTERN_TOP, '0);
    write_reg(CFG_PATTERN_LENGTH, 64'd2);
    write_reg(CFG_MAX_ERRORS, 64'd0);
    for (n = 0; n < FILL_BYTES; n++) send_byte("z", n == 0, 1'b0);
    send_byte("a", 1'b0, 1'b0);
    send_byte("b", 1'b0, 1'b1);
    wait_quiet();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Every single-byte text matches, so results pile up behind a stalled
  // receiver and the input has to stall too.
  task automatic test_backpressure();
    write_reg(CFG_PATTERN_LO, 64'h51);
    write_reg(CFG_PATTERN_LENGTH, 64'd1);
    write_reg(CFG_MAX_ERRORS, 64'd0);
    tx_idle_on = 1'b0;
    stall_req  = 1'b1;
    repeat (40) send_byte(8'h51, 1'b1, 1'b1);
    wait_quiet();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_texts();
    logic [63:0] words [4];
    logic [7:0]  alpha [4];
    logic [4:0]  plen;
    logic [2:0]  kerr;
    logic [7:0]  b;
    logic        sot, eot;
    int unsigned goal, phase, sent, tlen, p, m, kind, i, j, q;
    goal  = live_items + RANDOM_ITEMS;
    phase = 0;
    while (live_items < goal) begin
      case (phase % 8)
        1:       plen = 5'd31;
        3:       plen = 5'd1;
        5:       plen = 5'd0;
        7:       plen = 5'($urandom_range(9, 30));
        default: plen = 5'($urandom_range(2, 8));
      endcase
      case (phase % 3)
        0:       kerr = 3'd0;
        1:       kerr = 3'd7;
        default: kerr = 3'($urandom_range(1, 6));
      endcase
      for (i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(255));
      for (q = 0; q < 4; q++) begin
        for (i = 0; i < 8; i++) begin
          if (phase % 4 != 2 && q * 8 + i < plen)
            words[q][i * 8 +: 8] = alpha[$urandom_range(3)];
          else
            words[q][i * 8 +: 8] = 8'($urandom_range(255));
        end
      end
      // One phase runs with no idling on either side.
      tx_idle_on = (phase != 2);
      rx_idle_on = (phase != 2);
      write_reg(CFG_PATTERN_LENGTH, 64'(plen));
      write_reg(CFG_MAX_ERRORS, 64'(kerr));
      write_reg(CFG_PATTERN_LO, words[0]);
      write_reg(CFG_PATTERN_MID, words[1]);
      write_reg(CFG_PATTERN_HIGH, words[2]);
      write_reg(CFG_PATTERN_TOP, words[3]);
      sent = 0;
      while (sent < PHASE_BYTES && live_items < goal) begin
        tlen = $urandom_range(1, plen + 10);
        kind = $urandom_range(99);
        p    = ($urandom_range(3) == 0) ? $urandom_range(31) : 0;
        for (j = 0; j < tlen; j++) begin
          m = $urandom_range(99);
          if (plen == 0 || m < 8) begin
            b = 8'($urandom_range(255));
          end else begin
            if (m < 13) p++;
            b = words[(p % plen) / 8][((p % plen) % 8) * 8 +: 8];
            if (m >= 18) p++;
          end
          // Mostly well-formed texts; a few lack a start or an end marker,
          // or carry stray markers in the middle.
          sot = (j == 0 && kind >= 8) || (kind < 4 && $urandom_range(19) == 0);
          eot = (j == tlen - 1 && !(kind >= 8 && kind < 14))
                || (kind < 4 && $urandom_range(19) == 0);
          send_byte(b, sot, eot);
          sent++;
        end
      end
      wait_quiet();
      phase++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_text();
    test_backpressure();
    test_random_texts();
    wait_quiet();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
